// File: design/okvt_pkg.sv
`default_nettype none
package okvt_pkg;

	localparam logic [2:0] CMD_INSERT      = 3'd0;
	localparam logic [2:0] CMD_LOOKUP      = 3'd1;
	localparam logic [2:0] CMD_UPDATE      = 3'd2;
	localparam logic [2:0] CMD_POP         = 3'd3;
	localparam logic [2:0] CMD_REMOVE_NTH  = 3'd4;
	localparam logic [2:0] CMD_REMOVE_ALL  = 3'd5;
	localparam logic [2:0] CMD_REMOVE_LAST = 3'd6;

	localparam int COUNT_W = 5;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  entry_key;
		logic [63:0] entry_value;
		logic [4:0]  occurrence;
	} in_t;

	typedef struct packed {
		logic                hit;
		logic [63:0]         read_value;
		logic [COUNT_W-1:0]  entry_count;
		logic                insert_dropped;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_SCAN,
		DP_WRITE,
		DP_APPEND,
		DP_REJECT,
		DP_READ,
		DP_POP,
		DP_DROP_FIRST_V,
		DP_SKIP_FIRST_V,
		DP_DROP_LAST_V
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   publish;
	} ctrl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       key_hit;
		logic       val_hit;
		logic       full;
		logic       occ_zero;
		logic       occ_one;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: design/okvt_ctrl.sv
`default_nettype none
module okvt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire okvt_pkg::stat_t stat,
	output okvt_pkg::ctrl_t     ctrl
);
	import okvt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		ctrl.op      = DP_NONE;
		ctrl.publish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctrl.op = DP_LOAD;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctrl.op = DP_SCAN;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				case (stat.cmd)
					CMD_INSERT: begin
						if (stat.key_hit) begin
							ctrl.op = DP_WRITE;
						end else if (!stat.full) begin
							ctrl.op = DP_APPEND;
						end else begin
							ctrl.op = DP_REJECT;
						end
					end
					CMD_LOOKUP: begin
						if (stat.key_hit) begin
							ctrl.op = DP_READ;
						end
					end
					CMD_UPDATE: begin
						if (stat.key_hit) begin
							ctrl.op = DP_WRITE;
						end
					end
					CMD_POP: begin
						if (stat.key_hit) begin
							ctrl.op = DP_POP;
						end
					end
					CMD_REMOVE_NTH: begin
						if (!stat.occ_zero && stat.val_hit) begin
							if (stat.occ_one) begin
								ctrl.op = DP_DROP_FIRST_V;
							end else begin
								ctrl.op = DP_SKIP_FIRST_V;
								state_d = ST_EXEC;
							end
						end
					end
					CMD_REMOVE_ALL: begin
						if (stat.val_hit) begin
							ctrl.op = DP_DROP_FIRST_V;
							state_d = ST_EXEC;
						end
					end
					CMD_REMOVE_LAST: begin
						if (stat.val_hit) begin
							ctrl.op = DP_DROP_LAST_V;
						end
					end
					default: begin
						ctrl.op = DP_NONE;
					end
				endcase
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ctrl.publish = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/okvt_datapath.sv
`default_nettype none
module okvt_datapath #(
	parameter int CAPACITY = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire okvt_pkg::in_t   req,
	input  wire okvt_pkg::ctrl_t ctrl,
	output okvt_pkg::stat_t      stat,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output okvt_pkg::out_t       rsp
);
	import okvt_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FW = $clog2(CAPACITY + 1);

	in_t                 item_q;
	logic [7:0]          key_q [CAPACITY];
	logic [63:0]         val_q [CAPACITY];
	logic [FW-1:0]       fill_q;
	logic [CAPACITY-1:0] km_q;
	logic [CAPACITY-1:0] vm_q;
	logic [4:0]          cnt_q;
	logic                hit_q;
	logic [63:0]         rd_q;
	logic                drop_q;
	logic                rsp_valid_q;
	out_t                rsp_q;

	logic [CAPACITY-1:0] km;
	logic [CAPACITY-1:0] vm;
	logic [CAPACITY-1:0] vm_shift;
	logic [IW-1:0]       kidx;
	logic [IW-1:0]       vfirst;
	logic [IW-1:0]       vlast;
	logic [IW-1:0]       dpos;
	logic                do_drop;
	logic                full;
	logic                out_free;

	assign full     = (fill_q == FW'(CAPACITY));
	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			km[i] = (FW'(i) < fill_q) && (key_q[i] == item_q.entry_key);
			vm[i] = (FW'(i) < fill_q) && (val_q[i] == item_q.entry_value);
		end
	end

	// lowest set bit of each vector; highest for the last value match
	always_comb begin
		kidx   = '0;
		vfirst = '0;
		vlast  = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (km_q[i]) begin
				kidx = IW'(i);
			end
			if (vm_q[i]) begin
				vfirst = IW'(i);
			end
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (vm_q[i]) begin
				vlast = IW'(i);
			end
		end
	end

	always_comb begin
		case (ctrl.op)
			DP_POP: begin
				dpos    = kidx;
				do_drop = 1'b1;
			end
			DP_DROP_FIRST_V: begin
				dpos    = vfirst;
				do_drop = 1'b1;
			end
			DP_DROP_LAST_V: begin
				dpos    = vlast;
				do_drop = 1'b1;
			end
			default: begin
				dpos    = kidx;
				do_drop = 1'b0;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (IW'(i) < dpos) begin
				vm_shift[i] = vm_q[i];
			end else if (i < CAPACITY - 1) begin
				vm_shift[i] = vm_q[(i < CAPACITY - 1) ? i + 1 : i];
			end else begin
				vm_shift[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_drop) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (IW'(i) >= dpos) begin
					key_q[i] <= key_q[(i < CAPACITY - 1) ? i + 1 : i];
					val_q[i] <= val_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
		case (ctrl.op)
			DP_WRITE: begin
				val_q[kidx] <= item_q.entry_value;
			end
			DP_APPEND: begin
				key_q[fill_q[IW-1:0]] <= item_q.entry_key;
				val_q[fill_q[IW-1:0]] <= item_q.entry_value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			DP_LOAD: begin
				item_q <= req;
				hit_q  <= 1'b0;
				rd_q   <= '0;
				drop_q <= 1'b0;
			end
			DP_SCAN: begin
				km_q  <= km;
				vm_q  <= vm;
				cnt_q <= item_q.occurrence;
			end
			DP_WRITE: begin
				hit_q <= 1'b1;
			end
			DP_REJECT: begin
				drop_q <= 1'b1;
			end
			DP_READ, DP_POP: begin
				hit_q <= 1'b1;
				rd_q  <= val_q[kidx];
			end
			DP_DROP_FIRST_V: begin
				hit_q <= 1'b1;
				vm_q  <= vm_shift;
			end
			DP_SKIP_FIRST_V: begin
				vm_q  <= vm_q & (vm_q - 1'b1);
				cnt_q <= cnt_q - 5'd1;
			end
			DP_DROP_LAST_V: begin
				hit_q <= 1'b1;
			end
			default: begin
			end
		endcase
		if (ctrl.publish) begin
			rsp_q.hit            <= hit_q;
			rsp_q.read_value     <= rd_q;
			rsp_q.entry_count    <= COUNT_W'(fill_q);
			rsp_q.insert_dropped <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (do_drop) begin
				fill_q <= fill_q - 1'b1;
			end else if (ctrl.op == DP_APPEND) begin
				fill_q <= fill_q + 1'b1;
			end
			if (ctrl.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.cmd      = item_q.cmd;
	assign stat.key_hit  = |km_q;
	assign stat.val_hit  = |vm_q;
	assign stat.full     = full;
	assign stat.occ_zero = (cnt_q == 5'd0);
	assign stat.occ_one  = (cnt_q == 5'd1);
	assign stat.out_free = out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// File: design/ordered_key_value_table_unit.sv
// Ordered table of up to CAPACITY byte keys with 64-bit values, kept in insertion order
// with no gaps. One request beat gives exactly one response beat. A request goes through
// accept, a compare of all entries in parallel, the act step and the hand-over of the
// result to the output register; remove-nth repeats the act step for each skipped match
// before the one it removes, and remove-all for each entry it removes, as each removal
// shifts the later entries down one place. A new request is taken once the previous
// result sits in the output register, even while that result waits for rsp_ready.
// Inserting a new key into a full table leaves it unchanged and sets insert_dropped.
// entry_count shows the low five bits of the fill.
`default_nettype none
module ordered_key_value_table_unit #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire okvt_pkg::in_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output okvt_pkg::out_t     rsp
);
	import okvt_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	okvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	okvt_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctrl      (ctrl),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// File: design/okvt_checker.sv
`default_nettype none
module okvt_checker #(
	parameter int CAPACITY = 16
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire okvt_pkg::out_t rsp
);
	import okvt_pkg::*;

	logic [COUNT_W-1:0] cap_low;
	assign cap_low = COUNT_W'(CAPACITY);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.insert_dropped |-> !rsp.hit && rsp.read_value == 64'd0)
		else $error("dropped insert reported a hit or a value");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.insert_dropped |-> rsp.entry_count == cap_low)
		else $error("insert dropped while table not full");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.read_value != 64'd0 |-> rsp.hit)
		else $error("value returned on a miss");

	a_no_accept_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken before previous one finished");

endmodule

bind ordered_key_value_table_unit okvt_checker #(.CAPACITY(CAPACITY)) u_okvt_checker (.*);
`default_nettype wire

// File: tb/sv/tb_ordered_key_value_table_unit.sv
`default_nettype none
module tb_ordered_key_value_table_unit;
	import okvt_pkg::*;

	localparam int          CAPACITY    = 16;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          RAND_BLOCKS = 7;
	localparam int          BLOCK_ITEMS = 250;
	localparam logic [2:0]  CMD_NOP     = 3'd7;
	localparam logic [63:0] V_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] V_PAT       = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] V_ALT_A     = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] V_ALT_5     = 64'h5555_5555_5555_5555;
	localparam logic [63:0] V_POOL [4]  = '{64'h0, V_ONES, 64'hA5A5_5A5A_0F0F_F0F0, 64'd1};

	typedef struct {
		in_t  item;
		int   reps;
		bit   typed;
		out_t want;
	} dir_row_t;

	localparam int N_DIR = 22;

	// reps > 1 repeats the row with the key stepped by one each time
	dir_row_t dir_rows [N_DIR] = '{
		'{'{CMD_LOOKUP,      8'h00, 64'h0,   5'd0},  1, 1'b1, '{1'b0, 64'h0, 5'd0, 1'b0}},
		'{'{CMD_POP,         8'hFF, 64'h0,   5'd0},  1, 1'b1, '{1'b0, 64'h0, 5'd0, 1'b0}},
		'{'{CMD_REMOVE_ALL,  8'h00, 64'h0,   5'd0},  1, 1'b1, '{1'b0, 64'h0, 5'd0, 1'b0}},
		'{'{CMD_REMOVE_LAST, 8'h00, V_ONES,  5'd1},  1, 1'b1, '{1'b0, 64'h0, 5'd0, 1'b0}},
		'{'{CMD_INSERT,      8'h00, 64'h0,   5'd0},  1, 1'b1, '{1'b0, 64'h0, 5'd1, 1'b0}},
		'{'{CMD_INSERT,      8'hFF, V_ONES,  5'd0},  1, 1'b1, '{1'b0, 64'h0, 5'd2, 1'b0}},
		'{'{CMD_LOOKUP,      8'hFF, 64'h0,   5'd0},  1, 1'b1, '{1'b1, V_ONES, 5'd2, 1'b0}},
		'{'{CMD_INSERT,      8'hFF, V_ALT_5, 5'd0},  1, 1'b1, '{1'b1, 64'h0, 5'd2, 1'b0}},
		'{'{CMD_UPDATE,      8'h12, 64'h0,   5'd0},  1, 1'b1, '{1'b0, 64'h0, 5'd2, 1'b0}},
		'{'{CMD_UPDATE,      8'h00, V_ALT_A, 5'd0},  1, 1'b1, '{1'b1, 64'h0, 5'd2, 1'b0}},
		'{'{CMD_NOP,         8'hFF, V_ONES,  5'd31}, 1, 1'b1, '{1'b0, 64'h0, 5'd2, 1'b0}},
		'{'{CMD_INSERT,      8'h10, V_PAT,   5'd0}, 14, 1'b0, '0},
		'{'{CMD_INSERT,      8'h80, 64'h0,   5'd0},  1, 1'b1, '{1'b0, 64'h0, 5'd16, 1'b1}},
		'{'{CMD_INSERT,      8'h10, 64'h1234, 5'd0}, 1, 1'b1, '{1'b1, 64'h0, 5'd16, 1'b0}},
		'{'{CMD_REMOVE_NTH,  8'h00, V_PAT,   5'd0},  1, 1'b1, '{1'b0, 64'h0, 5'd16, 1'b0}},
		'{'{CMD_REMOVE_NTH,  8'h00, V_PAT,   5'd31}, 1, 1'b1, '{1'b0, 64'h0, 5'd16, 1'b0}},
		'{'{CMD_REMOVE_NTH,  8'h00, V_PAT,   5'd3},  1, 1'b1, '{1'b1, 64'h0, 5'd15, 1'b0}},
		'{'{CMD_REMOVE_LAST, 8'h00, V_PAT,   5'd0},  1, 1'b1, '{1'b1, 64'h0, 5'd14, 1'b0}},
		'{'{CMD_POP,         8'h00, 64'h0,   5'd0},  1, 1'b1, '{1'b1, V_ALT_A, 5'd13, 1'b0}},
		'{'{CMD_REMOVE_ALL,  8'h00, V_PAT,   5'd0},  1, 1'b0, '0},
		'{'{CMD_REMOVE_ALL,  8'h00, V_PAT,   5'd0},  1, 1'b1, '{1'b0, 64'h0, 5'd2, 1'b0}},
		'{'{CMD_LOOKUP,      8'h10, 64'h0,   5'd0},  1, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	in_t  req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	out_t rsp;

	logic [7:0]  tbl_key [CAPACITY];
	logic [63:0] tbl_val [CAPACITY];
	int          tbl_fill = 0;

	out_t results_due [$];
	int   fail_count = 0;
	int   cycle_count = 0;
	int   gap_pct = 0;
	int   stall_pct = 0;
	int   stall_left = 0;

	ordered_key_value_table_unit #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	function automatic int tbl_find(logic [7:0] k);
		for (int i = 0; i < tbl_fill; i++)
			if (tbl_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void tbl_remove_at(int pos);
		for (int i = pos; i + 1 < tbl_fill; i++) begin
			tbl_key[i] = tbl_key[i + 1];
			tbl_val[i] = tbl_val[i + 1];
		end
		tbl_fill--;
	endfunction

	function automatic out_t table_apply(in_t item);
		out_t r;
		int pos;
		int seen;
		int i;
		r = '0;
		case (item.cmd)
		CMD_INSERT: begin
			pos = tbl_find(item.entry_key);
			if (pos >= 0) begin
				tbl_val[pos] = item.entry_value;
				r.hit = 1'b1;
			end else if (tbl_fill < CAPACITY) begin
				tbl_key[tbl_fill] = item.entry_key;
				tbl_val[tbl_fill] = item.entry_value;
				tbl_fill++;
			end else begin
				r.insert_dropped = 1'b1;
			end
		end
		CMD_LOOKUP, CMD_POP: begin
			pos = tbl_find(item.entry_key);
			if (pos >= 0) begin
				r.hit = 1'b1;
				r.read_value = tbl_val[pos];
				if (item.cmd == CMD_POP)
					tbl_remove_at(pos);
			end
		end
		CMD_UPDATE: begin
			pos = tbl_find(item.entry_key);
			if (pos >= 0) begin
				tbl_val[pos] = item.entry_value;
				r.hit = 1'b1;
			end
		end
		CMD_REMOVE_NTH: begin
			seen = 0;
			for (i = 0; i < tbl_fill; i++) begin
				if (tbl_val[i] == item.entry_value) begin
					seen++;
					if (seen == item.occurrence) begin
						tbl_remove_at(i);
						r.hit = 1'b1;
						break;
					end
				end
			end
		end
		CMD_REMOVE_ALL: begin
			i = 0;
			while (i < tbl_fill) begin
				if (tbl_val[i] == item.entry_value) begin
					tbl_remove_at(i);
					r.hit = 1'b1;
				end else begin
					i++;
				end
			end
		end
		CMD_REMOVE_LAST: begin
			for (i = tbl_fill - 1; i >= 0; i--) begin
				if (tbl_val[i] == item.entry_value) begin
					tbl_remove_at(i);
					r.hit = 1'b1;
					break;
				end
			end
		end
		default: begin
		end
		endcase
		r.entry_count = COUNT_W'(tbl_fill);
		return r;
	endfunction

	// fill_bias favours inserts so the table keeps hitting full
	function automatic in_t random_request(bit fill_bias);
		in_t it;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < (fill_bias ? 40 : 20)) begin
			it.cmd = CMD_INSERT;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 20)      it.cmd = CMD_LOOKUP;
			else if (roll < 33) it.cmd = CMD_UPDATE;
			else if (roll < 53) it.cmd = CMD_POP;
			else if (roll < 70) it.cmd = CMD_REMOVE_NTH;
			else if (roll < 80) it.cmd = CMD_REMOVE_ALL;
			else if (roll < 96) it.cmd = CMD_REMOVE_LAST;
			else                it.cmd = CMD_NOP;
		end
		it.entry_key = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
		it.entry_value = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
		                                             : V_POOL[$urandom_range(0, 3)];
		it.occurrence = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
		                                            : 5'($urandom_range(0, 4));
		return it;
	endfunction

	task automatic send_request(in_t item, bit typed, out_t want);
		out_t pred;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pred = table_apply(item);
		results_due.push_back(typed ? want : pred);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 9);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected beat: hit=%0b rd=%h cnt=%0d drop=%0b",
						rsp.hit, rsp.read_value, rsp.entry_count, rsp.insert_dropped);
			end else begin
				want = results_due.pop_front();
				if (rsp.hit !== want.hit || rsp.read_value !== want.read_value ||
				    rsp.entry_count !== want.entry_count ||
				    rsp.insert_dropped !== want.insert_dropped) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: exp hit=%0b rd=%h cnt=%0d drop=%0b, got hit=%0b rd=%h cnt=%0d drop=%0b",
							want.hit, want.read_value, want.entry_count, want.insert_dropped,
							rsp.hit, rsp.read_value, rsp.entry_count, rsp.insert_dropped);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		in_t it;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 20;
		stall_pct = 20;
		foreach (dir_rows[r]) begin
			for (int k = 0; k < dir_rows[r].reps; k++) begin
				it = dir_rows[r].item;
				it.entry_key = it.entry_key + 8'(k);
				send_request(it, dir_rows[r].typed, dir_rows[r].want);
			end
		end

		for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
			gap_pct = (blk == RAND_BLOCKS - 1) ? 0 : 15 * $urandom_range(0, 3);
			stall_pct = (blk == RAND_BLOCKS - 1) ? 0 : 15 * $urandom_range(0, 3);
			for (int n = 0; n < BLOCK_ITEMS; n++)
				send_request(random_request(blk % 2 == 0), 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
